>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed: lbl");
// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and helpers shared by the LCD nibble interface.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int unsigned PC_W = 6;

	// request modes
	localparam logic [1:0] MODE_INIT   = 2'd0;
	localparam logic [1:0] MODE_CMD    = 2'd1;
	localparam logic [1:0] MODE_DATA   = 2'd2;
	localparam logic [1:0] MODE_CURSOR = 2'd3;

	// program entry points
	localparam logic [PC_W-1:0] ENTRY_INIT   = 6'd0;
	localparam logic [PC_W-1:0] ENTRY_BYTE   = 6'd25;
	localparam logic [PC_W-1:0] ENTRY_CURSOR = 6'd29;

	localparam logic [7:0] SET_DDRAM = 8'h80;

	typedef enum logic [1:0] {
		NIB_KEEP  = 2'd0,
		NIB_CONST = 2'd1,
		NIB_HI    = 2'd2,
		NIB_LO    = 2'd3
	} nib_sel_t;

	typedef enum logic [2:0] {
		HOLD_PULSE = 3'd0,  // 5 us enable pulse / low phase
		HOLD_POWER = 3'd1,  // 40 ms power-up wait
		HOLD_INIT  = 3'd2,  // 5 + 5000 us after init nibble
		HOLD_LONG  = 3'd3,  // 5 + 50 + 2000 us after slow command
		HOLD_BYTE  = 3'd4   // 5 + 50 us after ordinary byte
	} hold_code_t;

	typedef struct packed {
		nib_sel_t   nib_sel;
		logic [3:0] nib_const;
		logic       en;
		hold_code_t hold;
		logic       last;
	} ctrl_word_t;

	typedef struct packed {
		logic accept;  // input item taken this cycle
		logic step;    // control word executed this cycle
	} seq_ctl_t;

	function automatic ctrl_word_t mk_word(nib_sel_t sel, logic [3:0] nib, logic en,
			hold_code_t hold, logic last);
		ctrl_word_t w;
		w.nib_sel   = sel;
		w.nib_const = nib;
		w.en        = en;
		w.hold      = hold;
		w.last      = last;
		return w;
	endfunction

	function automatic logic [15:0] hold_value(hold_code_t code);
		logic [15:0] v;
		unique case (code)
			HOLD_PULSE: v = 16'd5;
			HOLD_POWER: v = 16'd40000;
			HOLD_INIT:  v = 16'd5005;
			HOLD_LONG:  v = 16'd2055;
			HOLD_BYTE:  v = 16'd55;
			default:    v = 16'd5;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] row_base(logic [1:0] row);
		logic [6:0] b;
		unique case (row)
			2'd0:    b = 7'h00;
			2'd1:    b = 7'h40;
			2'd2:    b = 7'h10;
			default: b = 7'h50;
		endcase
		return b;
	endfunction

endpackage

>>> src/clcd_prog_rom.sv
// ----------------------------------------------------------------------------
// clcd_prog_rom
// Microprogram: one control word per pin step.
// ----------------------------------------------------------------------------
module clcd_prog_rom import clcd_pkg::*; (
	input  logic [PC_W-1:0] pc,
	output ctrl_word_t      word
);

	always_comb begin
		unique case (pc)
			// initialise: power wait, then 3,3,3,2 nibbles
			6'd0:  word = mk_word(NIB_KEEP,  4'h0, 1'b0, HOLD_POWER, 1'b0);
			6'd1:  word = mk_word(NIB_CONST, 4'h3, 1'b1, HOLD_PULSE, 1'b0);
			6'd2:  word = mk_word(NIB_CONST, 4'h3, 1'b0, HOLD_INIT,  1'b0);
			6'd3:  word = mk_word(NIB_CONST, 4'h3, 1'b1, HOLD_PULSE, 1'b0);
			6'd4:  word = mk_word(NIB_CONST, 4'h3, 1'b0, HOLD_INIT,  1'b0);
			6'd5:  word = mk_word(NIB_CONST, 4'h3, 1'b1, HOLD_PULSE, 1'b0);
			6'd6:  word = mk_word(NIB_CONST, 4'h3, 1'b0, HOLD_INIT,  1'b0);
			6'd7:  word = mk_word(NIB_CONST, 4'h2, 1'b1, HOLD_PULSE, 1'b0);
			6'd8:  word = mk_word(NIB_CONST, 4'h2, 1'b0, HOLD_INIT,  1'b0);
			// function set 0x28
			6'd9:  word = mk_word(NIB_CONST, 4'h2, 1'b1, HOLD_PULSE, 1'b0);
			6'd10: word = mk_word(NIB_CONST, 4'h2, 1'b0, HOLD_PULSE, 1'b0);
			6'd11: word = mk_word(NIB_CONST, 4'h8, 1'b1, HOLD_PULSE, 1'b0);
			6'd12: word = mk_word(NIB_CONST, 4'h8, 1'b0, HOLD_LONG,  1'b0);
			// display on 0x0C
			6'd13: word = mk_word(NIB_CONST, 4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd14: word = mk_word(NIB_CONST, 4'h0, 1'b0, HOLD_PULSE, 1'b0);
			6'd15: word = mk_word(NIB_CONST, 4'hC, 1'b1, HOLD_PULSE, 1'b0);
			6'd16: word = mk_word(NIB_CONST, 4'hC, 1'b0, HOLD_LONG,  1'b0);
			// entry mode 0x06
			6'd17: word = mk_word(NIB_CONST, 4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd18: word = mk_word(NIB_CONST, 4'h0, 1'b0, HOLD_PULSE, 1'b0);
			6'd19: word = mk_word(NIB_CONST, 4'h6, 1'b1, HOLD_PULSE, 1'b0);
			6'd20: word = mk_word(NIB_CONST, 4'h6, 1'b0, HOLD_LONG,  1'b0);
			// clear 0x01
			6'd21: word = mk_word(NIB_CONST, 4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd22: word = mk_word(NIB_CONST, 4'h0, 1'b0, HOLD_PULSE, 1'b0);
			6'd23: word = mk_word(NIB_CONST, 4'h1, 1'b1, HOLD_PULSE, 1'b0);
			6'd24: word = mk_word(NIB_CONST, 4'h1, 1'b0, HOLD_LONG,  1'b1);
			// command / data byte from byte register
			6'd25: word = mk_word(NIB_HI,    4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd26: word = mk_word(NIB_HI,    4'h0, 1'b0, HOLD_PULSE, 1'b0);
			6'd27: word = mk_word(NIB_LO,    4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd28: word = mk_word(NIB_LO,    4'h0, 1'b0, HOLD_BYTE,  1'b1);
			// cursor address command
			6'd29: word = mk_word(NIB_HI,    4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd30: word = mk_word(NIB_HI,    4'h0, 1'b0, HOLD_PULSE, 1'b0);
			6'd31: word = mk_word(NIB_LO,    4'h0, 1'b1, HOLD_PULSE, 1'b0);
			6'd32: word = mk_word(NIB_LO,    4'h0, 1'b0, HOLD_LONG,  1'b1);
			default: word = mk_word(NIB_KEEP, 4'h0, 1'b0, HOLD_PULSE, 1'b1);
		endcase
	end

endmodule

>>> src/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Step counter with mode dispatch; steps run while the output slot frees.
// ----------------------------------------------------------------------------
module clcd_seq import clcd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      mode,
	input  logic            out_valid,
	input  logic            out_stall,
	input  ctrl_word_t      word,
	output logic            in_stall,
	output logic            busy,
	output logic [PC_W-1:0] pc,
	output seq_ctl_t        ctl
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] entry;

	always_comb begin
		unique case (mode)
			MODE_INIT:   entry = ENTRY_INIT;
			MODE_CURSOR: entry = ENTRY_CURSOR;
			default:     entry = ENTRY_BYTE;
		endcase
	end

	assign ctl.step   = busy_q & (~out_valid | ~out_stall);
	// a new item may enter on the edge that issues the final step
	assign in_stall   = busy_q & ~(ctl.step & word.last);
	assign ctl.accept = in_valid & ~in_stall;
	assign busy       = busy_q;
	assign pc         = pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (ctl.accept) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (ctl.step) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

>>> src/clcd_dp.sv
// ----------------------------------------------------------------------------
// clcd_dp
// Pin-level datapath: RS, byte and data-line registers plus output slot.
// ----------------------------------------------------------------------------
module clcd_dp import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_ctl_t    ctl,
	input  ctrl_word_t  word,
	input  logic [1:0]  mode,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [3:0]  col,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        reg_select,
	output logic        enable_pin,
	output logic [3:0]  data_nibble,
	output logic [15:0] hold_us,
	output logic        last
);

	logic        rs_q;
	logic [3:0]  lines_q;
	logic [7:0]  byte_q;
	logic        out_valid_q;
	logic        rs_out_q;
	logic        en_out_q;
	logic [3:0]  nib_out_q;
	logic [15:0] hold_out_q;
	logic        last_out_q;
	logic [3:0]  nib;
	logic [6:0]  addr;

	assign addr = row_base(row) + {3'b000, col};

	always_comb begin
		unique case (word.nib_sel)
			NIB_KEEP:  nib = lines_q;
			NIB_CONST: nib = word.nib_const;
			NIB_HI:    nib = byte_q[7:4];
			NIB_LO:    nib = byte_q[3:0];
			default:   nib = lines_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q        <= 1'b0;
			lines_q     <= 4'h0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				rs_q <= (mode == MODE_DATA);
			end
			if (ctl.step) begin
				lines_q     <= nib;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			byte_q <= (mode == MODE_CURSOR) ? (SET_DDRAM | {1'b0, addr}) : value;
		end
		if (ctl.step) begin
			rs_out_q   <= rs_q;
			en_out_q   <= word.en;
			nib_out_q  <= nib;
			hold_out_q <= hold_value(word.hold);
			last_out_q <= word.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_select  = rs_out_q;
	assign enable_pin  = en_out_q;
	assign data_nibble = nib_out_q;
	assign hold_us     = hold_out_q;
	assign last        = last_out_q;

endmodule

>>> src/char_lcd_nibble_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Character LCD 4-bit bus driver: expands each request into timed pin steps.
// ----------------------------------------------------------------------------
//  channel | signals                                     | flow
//  --------+---------------------------------------------+-------------------
//  in      | in_valid, in_stall, mode, value, row, col   | request, one item
//  out     | out_valid, out_stall, reg_select,           | one pin step/item
//          | enable_pin, data_nibble, hold_us, last      |
//
//  One pin step leaves per clock while out is not stalled; a byte request
//  gives 4 steps, initialise gives 25 steps. The step counter walks the
//  microprogram one control word per cycle while out is not stalled. A new
//  request enters in the same cycle its predecessor's final step is issued.
//  Reset clears the sequencer, RS and data-line levels to zero.
//  A stall on out freezes the output register and the step counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_interface import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [3:0]  col,
	// pin step channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic        enable_pin,
	output logic [3:0]  data_nibble,
	output logic [15:0] hold_us,
	output logic        last
);

	logic [PC_W-1:0] pc;
	ctrl_word_t      word;
	seq_ctl_t        ctl;
	logic            busy;

	// sequencer: step counter and dispatch on request mode
	clcd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word      (word),
		.in_stall  (in_stall),
		.busy      (busy),
		.pc        (pc),
		.ctl       (ctl)
	);

	// microprogram store
	clcd_prog_rom u_rom (
		.pc   (pc),
		.word (word)
	);

	// pin datapath and output slot
	clcd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.word        (word),
		.mode        (mode),
		.value       (value),
		.row         (row),
		.col         (col),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.reg_select  (reg_select),
		.enable_pin  (enable_pin),
		.data_nibble (data_nibble),
		.hold_us     (hold_us),
		.last        (last)
	);

	// a request only overlaps a running one on its final step
	`ASSERT_ALWAYS(a_accept_overlap, !(ctl.accept && busy) || (ctl.step && word.last))
	// every issued step shows up on the output
	`ASSERT_NEXT(a_step_shown, ctl.step, out_valid)
	// the enable pulse is never the final step of a request
	`ASSERT_ALWAYS(a_en_not_last, !(out_valid && enable_pin && last))
	// the sequencer goes idle after the final step unless refilled
	`ASSERT_NEXT(a_idle_after_last, ctl.step && word.last && !ctl.accept, !busy)

endmodule
